// ===== rtl/scq_pkg.sv =====
// ----------------------------------------------------------------------------
// scq_pkg
// Shared types, constants and codes of the two-class oldest-first queue.
// ----------------------------------------------------------------------------
package scq_pkg;

  localparam int CLASS_DEPTH = 16;
  localparam int TOKEN_BITS  = 32;

  localparam int IDX_W     = $clog2(CLASS_DEPTH);
  localparam int CNT_W     = $clog2(CLASS_DEPTH + 1);
  localparam int STAMP_MOD = 4 * CLASS_DEPTH;
  localparam int STAMP_W   = $clog2(STAMP_MOD);
  localparam int ENTRY_W   = STAMP_W + TOKEN_BITS;

  typedef logic [TOKEN_BITS-1:0] token_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [STAMP_W-1:0]    stamp_t;

  typedef enum logic [2:0] {
    OP_ENQUEUE  = 3'd0,
    OP_DEQ_ANY  = 3'd1,
    OP_DEQ_FIRST  = 3'd2,
    OP_DEQ_SECOND = 3'd3,
    OP_QUERY    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NO_CLASS = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0] operation;
    logic       item_class;
    token_t     item_token;
  } req_t;

  typedef struct packed {
    token_t     served_token;
    logic       served_class;
    logic [1:0] status;
    logic       all_empty;
  } rsp_t;

  // Handshake between the sequencer and the queue core.
  typedef struct packed {
    logic rd_en;
    logic commit;
  } ctrl_t;

endpackage

// ===== rtl/scq_if.sv =====
// ----------------------------------------------------------------------------
// scq_req_if / scq_rsp_if
// Valid/ready channels for requests and results of the queue.
// ----------------------------------------------------------------------------
interface scq_req_if;
  logic                valid;
  logic                ready;
  logic [2:0]          operation;
  logic                item_class;
  scq_pkg::token_t     item_token;

  modport source (output valid, operation, item_class, item_token, input ready);
  modport sink   (input valid, operation, item_class, item_token, output ready);
endinterface

interface scq_rsp_if;
  logic                valid;
  logic                ready;
  scq_pkg::token_t     served_token;
  logic                served_class;
  logic [1:0]          status;
  logic                all_empty;

  modport source (output valid, served_token, served_class, status, all_empty,
                  input ready);
  modport sink   (input valid, served_token, served_class, status, all_empty,
                  output ready);
endinterface

// ===== rtl/scq_ram.sv =====
// ----------------------------------------------------------------------------
// scq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module scq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/scq_core.sv =====
// ----------------------------------------------------------------------------
// scq_core
// Class memories, ring pointers, fill counts and the arrival stamp, with the
// per-operation decision and write-back.
// ----------------------------------------------------------------------------
module scq_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  scq_pkg::ctrl_t  ctrl_i,
  input  scq_pkg::req_t   req_i,
  output scq_pkg::rsp_t   rsp_o
);

  localparam scq_pkg::cnt_t DEPTH_CNT = scq_pkg::CNT_W'(scq_pkg::CLASS_DEPTH);
  localparam logic [scq_pkg::IDX_W:0] DEPTH_SUM =
    (scq_pkg::IDX_W + 1)'(scq_pkg::CLASS_DEPTH);
  localparam scq_pkg::idx_t LAST_IDX = scq_pkg::IDX_W'(scq_pkg::CLASS_DEPTH - 1);
  localparam scq_pkg::stamp_t LAST_STAMP =
    scq_pkg::STAMP_W'(scq_pkg::STAMP_MOD - 1);
  localparam logic [scq_pkg::STAMP_W:0] STAMP_MOD_X =
    (scq_pkg::STAMP_W + 1)'(scq_pkg::STAMP_MOD);
  localparam logic [scq_pkg::STAMP_W:0] STAMP_HALF =
    (scq_pkg::STAMP_W + 1)'(scq_pkg::STAMP_MOD / 2);

  scq_pkg::idx_t   head0_q, head0_d, head1_q, head1_d;
  scq_pkg::cnt_t   cnt0_q, cnt0_d, cnt1_q, cnt1_d;
  scq_pkg::stamp_t stamp_q, stamp_d;

  logic [scq_pkg::ENTRY_W-1:0] rdata0, rdata1, wdata;
  logic                        we0, we1;
  scq_pkg::idx_t               waddr;

  scq_pkg::token_t tok0, tok1;
  scq_pkg::stamp_t hstamp0, hstamp1;

  logic                        empty0, empty1;
  logic                        pop0, pop1, pick;
  logic [1:0]                  status;
  logic [scq_pkg::IDX_W:0]     tail_sum;
  scq_pkg::idx_t               tail0, tail1;
  logic [scq_pkg::STAMP_W:0]   diff;
  logic                        older0;

  assign {hstamp0, tok0} = rdata0;
  assign {hstamp1, tok1} = rdata1;

  assign empty0 = (cnt0_q == '0);
  assign empty1 = (cnt1_q == '0);

  // Wrap-aware age: stamp of class 0 is older when the modular difference
  // lies in the upper half of the stamp range.
  always_comb begin
    if (hstamp0 >= hstamp1) begin
      diff = {1'b0, hstamp0} - {1'b0, hstamp1};
    end else begin
      diff = {1'b0, hstamp0} + STAMP_MOD_X - {1'b0, hstamp1};
    end
    older0 = (diff >= STAMP_HALF);
  end

  always_comb begin
    tail_sum = {1'b0, head0_q} + {1'b0, cnt0_q[scq_pkg::IDX_W-1:0]};
    tail0 = (tail_sum >= DEPTH_SUM) ? scq_pkg::IDX_W'(tail_sum - DEPTH_SUM)
                                    : tail_sum[scq_pkg::IDX_W-1:0];
  end

  always_comb begin
    logic [scq_pkg::IDX_W:0] sum1;
    sum1 = {1'b0, head1_q} + {1'b0, cnt1_q[scq_pkg::IDX_W-1:0]};
    tail1 = (sum1 >= DEPTH_SUM) ? scq_pkg::IDX_W'(sum1 - DEPTH_SUM)
                                : sum1[scq_pkg::IDX_W-1:0];
  end

  always_comb begin
    we0    = 1'b0;
    we1    = 1'b0;
    pop0   = 1'b0;
    pop1   = 1'b0;
    pick   = 1'b0;
    status = scq_pkg::ST_OK;
    case (req_i.operation)
      scq_pkg::OP_ENQUEUE: begin
        if (req_i.item_class) begin
          if (cnt1_q == DEPTH_CNT) begin
            status = scq_pkg::ST_FULL;
          end else begin
            we1 = 1'b1;
          end
        end else begin
          if (cnt0_q == DEPTH_CNT) begin
            status = scq_pkg::ST_FULL;
          end else begin
            we0 = 1'b1;
          end
        end
      end
      scq_pkg::OP_DEQ_ANY: begin
        if (empty0 && empty1) begin
          status = scq_pkg::ST_EMPTY;
        end else begin
          if (empty1) begin
            pick = 1'b0;
          end else if (empty0) begin
            pick = 1'b1;
          end else begin
            pick = !older0;
          end
          pop0 = !pick;
          pop1 = pick;
        end
      end
      scq_pkg::OP_DEQ_FIRST: begin
        if (empty0) begin
          status = scq_pkg::ST_NO_CLASS;
        end else begin
          pop0 = 1'b1;
        end
      end
      scq_pkg::OP_DEQ_SECOND: begin
        if (empty1) begin
          status = scq_pkg::ST_NO_CLASS;
        end else begin
          pick = 1'b1;
          pop1 = 1'b1;
        end
      end
      scq_pkg::OP_QUERY: begin
        status = (empty0 && empty1) ? scq_pkg::ST_EMPTY : scq_pkg::ST_OK;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    head0_d  = head0_q;
    head1_d  = head1_q;
    cnt0_d   = cnt0_q;
    cnt1_d   = cnt1_q;
    stamp_d  = stamp_q;
    if (pop0) begin
      head0_d = (head0_q == LAST_IDX) ? '0 : head0_q + 1'b1;
      cnt0_d  = cnt0_q - 1'b1;
    end
    if (pop1) begin
      head1_d = (head1_q == LAST_IDX) ? '0 : head1_q + 1'b1;
      cnt1_d  = cnt1_q - 1'b1;
    end
    if (we0) begin
      cnt0_d = cnt0_q + 1'b1;
    end
    if (we1) begin
      cnt1_d = cnt1_q + 1'b1;
    end
    if (we0 || we1) begin
      stamp_d = (stamp_q == LAST_STAMP) ? '0 : stamp_q + 1'b1;
    end
  end

  assign wdata = {stamp_q, req_i.item_token};
  assign waddr = req_i.item_class ? tail1 : tail0;

  always_comb begin
    rsp_o.served_token = '0;
    if (pop0) begin
      rsp_o.served_token = tok0;
    end else if (pop1) begin
      rsp_o.served_token = tok1;
    end
    rsp_o.served_class = pick && (pop0 || pop1);
    rsp_o.status       = status;
    rsp_o.all_empty    = (cnt0_d == '0) && (cnt1_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head0_q <= '0;
      head1_q <= '0;
      cnt0_q  <= '0;
      cnt1_q  <= '0;
      stamp_q <= '0;
    end else if (ctrl_i.commit) begin
      head0_q <= head0_d;
      head1_q <= head1_d;
      cnt0_q  <= cnt0_d;
      cnt1_q  <= cnt1_d;
      stamp_q <= stamp_d;
    end
  end

  // Both heads are read when a request is taken; writes land only at commit,
  // which always precedes the next read.
  scq_ram #(
    .DEPTH (scq_pkg::CLASS_DEPTH),
    .WIDTH (scq_pkg::ENTRY_W)
  ) u_ram_first (
    .clk_i   (clk_i),
    .we_i    (we0 && ctrl_i.commit),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ctrl_i.rd_en),
    .raddr_i (head0_q),
    .rdata_o (rdata0)
  );

  scq_ram #(
    .DEPTH (scq_pkg::CLASS_DEPTH),
    .WIDTH (scq_pkg::ENTRY_W)
  ) u_ram_second (
    .clk_i   (clk_i),
    .we_i    (we1 && ctrl_i.commit),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ctrl_i.rd_en),
    .raddr_i (head1_q),
    .rdata_o (rdata1)
  );

endmodule

// ===== rtl/two_class_fifo_oldest_first_top.sv =====
// ----------------------------------------------------------------------------
// two_class_fifo_oldest_first_top
// Two-class oldest-first queue with one result per request.
// ----------------------------------------------------------------------------
// Each request runs in two steps: on acceptance the head entries of both
// class memories are read into their registered read ports; in the execute
// state the operation is decided, the memory write and pointer updates are
// committed and the result is loaded into the output register. A new request
// is taken only after the previous one has committed. A finished result waits
// in the output register while the next request is already taken; the execute
// state of that request stretches until the output register frees up.
// ----------------------------------------------------------------------------
module two_class_fifo_oldest_first_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  scq_req_if.sink   req_i,
  scq_rsp_if.source rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e          state_q, state_d;
  scq_pkg::req_t   req_q;
  scq_pkg::rsp_t   result, out_q;
  scq_pkg::ctrl_t  ctrl;
  logic            out_valid_q;
  logic            out_free;
  logic            accept;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign ctrl.rd_en  = accept;
  assign ctrl.commit = (state_q == S_EXEC) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl.commit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.operation  <= req_i.operation;
      req_q.item_class <= req_i.item_class;
      req_q.item_token <= req_i.item_token;
    end
    if (ctrl.commit) begin
      out_q <= result;
    end
  end

  scq_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .req_i  (req_q),
    .rsp_o  (result)
  );

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.served_token = out_q.served_token;
  assign rsp_o.served_class = out_q.served_class;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.all_empty    = out_q.all_empty;

endmodule
